### sv/assert_macros.svh
// Assertion macros shared by the color mixer RTL.
// No dependencies; every macro disables itself while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### sv/rcm_pkg.sv
// Package for the RGB color mix accumulator: widths, mode and func codes,
// and the accumulator control struct. No dependencies.
`timescale 1ns / 1ps

package rcm_pkg;

    localparam int SUM_WIDTH   = 24;
    localparam int COUNT_WIDTH = 16;
    localparam int CHAN_W      = 8;
    localparam int MODE_W      = 3;
    localparam int FUNC_W      = 2;
    localparam int NUM_CHAN    = 3;
    localparam int DIVD_W      = SUM_WIDTH + CHAN_W;
    localparam int DIVS_W      = (SUM_WIDTH + 2 > COUNT_WIDTH) ? SUM_WIDTH + 2 : COUNT_WIDTH;
    localparam int CMP_W       = ((SUM_WIDTH > COUNT_WIDTH) ? SUM_WIDTH : COUNT_WIDTH) + CHAN_W;
    localparam int STEP_W      = $clog2(CHAN_W);

    localparam logic [MODE_W-1:0] MODE_CAP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAX  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NORM = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AVG  = 3'd4;

    localparam logic [FUNC_W-1:0] FUNC_ADD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLR = 2'd2;

    typedef logic [SUM_WIDTH-1:0] t_sum;
    typedef logic [DIVD_W-1:0]    t_dvd;
    typedef logic [DIVS_W-1:0]    t_dvs;
    typedef logic [CMP_W-1:0]     t_cmp;

    typedef struct packed {
        logic              add;
        logic              clr;
        logic              upd;
        logic [MODE_W-1:0] mode;
    } t_acc_ctrl;

    function automatic logic is_norm(input logic [MODE_W-1:0] mode);
        return mode inside {MODE_MAX, MODE_NORM, MODE_OVER};
    endfunction

endpackage

### sv/rcm_div.sv
// Bit-serial restoring divider lane: one quotient bit per step, 8-bit quotient.
// Depends on rcm_pkg. Requires dividend < divisor * 256 for a valid quotient.
`timescale 1ns / 1ps

module rcm_div import rcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic [CHAN_W-1:0] o_quot
);

    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [CHAN_W-1:0] r_lo;
    logic [CHAN_W-1:0] r_quot;
    logic [DIVS_W:0]   w_trial;
    logic [DIVS_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_lo[CHAN_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= t_dvs'(i_dividend[DIVD_W-1:CHAN_W]);
            r_lo   <= i_dividend[CHAN_W-1:0];
            r_dvs  <= i_divisor;
            r_quot <= '0;
        end else if (i_step) begin
            r_rem  <= w_ge ? w_diff[DIVS_W-1:0] : w_trial[DIVS_W-1:0];
            r_lo   <= {r_lo[CHAN_W-2:0], 1'b0};
            r_quot <= {r_quot[CHAN_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quot;

endmodule

### sv/rcm_acc.sv
// Channel accumulators, add count and pending flag of the color mixer.
// Depends on rcm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcm_acc import rcm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_acc_ctrl              i_ctrl,
    input  logic [CHAN_W-1:0]      i_red,
    input  logic [CHAN_W-1:0]      i_green,
    input  logic [CHAN_W-1:0]      i_blue,
    output logic [SUM_WIDTH-1:0]   o_red_sum,
    output logic [SUM_WIDTH-1:0]   o_green_sum,
    output logic [SUM_WIDTH-1:0]   o_blue_sum,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_pending
);

    logic [SUM_WIDTH-1:0]   r_red_sum, r_green_sum, r_blue_sum;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_pending;

    function automatic t_sum next_sum(input t_sum sum, input logic [CHAN_W-1:0] c,
                                      input logic [MODE_W-1:0] mode);
        logic [SUM_WIDTH:0] s;
        t_sum               ce;
        ce = t_sum'(c);
        s  = {1'b0, sum} + {1'b0, ce};
        case (mode)
            MODE_MAX:  return (ce > sum) ? ce : sum;
            MODE_OVER: return ce;
            default:   return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
        endcase
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_red_sum   <= '0;
            r_green_sum <= '0;
            r_blue_sum  <= '0;
            r_count     <= '0;
            r_pending   <= 1'b0;
        end else if (i_ctrl.add) begin
            r_red_sum   <= next_sum(r_red_sum, i_red, i_ctrl.mode);
            r_green_sum <= next_sum(r_green_sum, i_green, i_ctrl.mode);
            r_blue_sum  <= next_sum(r_blue_sum, i_blue, i_ctrl.mode);
            r_pending   <= 1'b1;
            if (i_ctrl.mode == MODE_AVG && r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
        end else if (i_ctrl.upd) begin
            r_pending <= 1'b0;
        end
    end

    assign o_red_sum   = r_red_sum;
    assign o_green_sum = r_green_sum;
    assign o_blue_sum  = r_blue_sum;
    assign o_count     = r_count;
    assign o_pending   = r_pending;

    `ASSERT_NEXT(a_clr_zero, i_clk, i_rst_n, i_ctrl.clr, r_count == '0 && !r_pending && r_red_sum == '0)
    `ASSERT_NEXT(a_cnt_avg_only, i_clk, i_rst_n, i_ctrl.mode != MODE_AVG && !i_ctrl.clr, r_count == $past(r_count))

endmodule

### sv/rgb_color_mix_accumulator.sv
// RGB color mix accumulator. An update beat with adds pending runs three
// bit-serial divider lanes in parallel, one quotient bit per cycle, and goes
// from acceptance through the divide steps, a finish step and an output load,
// which waits for a free output register; an update with nothing pending goes
// straight to the output load and repeats the held color. One beat is in flight
// at a time: the input is ready only when the sequencer is idle, while a finished
// result may wait in the output register. The mode register is written through
// its own channel, always ready, and must only change while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_color_mix_accumulator import rcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_mix_mode,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CHAN_W-1:0] i_red_in,
    input  logic [CHAN_W-1:0] i_green_in,
    input  logic [CHAN_W-1:0] i_blue_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAN_W-1:0] o_red_out,
    output logic [CHAN_W-1:0] o_green_out,
    output logic [CHAN_W-1:0] o_blue_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [STEP_W-1:0]      r_step_cnt, n_step_cnt;
    logic [MODE_W-1:0]      r_mix_mode;
    logic                   r_div_zero;
    logic [CHAN_W-1:0]      r_held [NUM_CHAN];
    logic                   r_out_valid;
    logic [CHAN_W-1:0]      r_out [NUM_CHAN];

    t_acc_ctrl              w_ctrl;
    logic                   w_in_acc;
    logic                   w_div_load;
    logic                   w_out_load;
    logic [SUM_WIDTH-1:0]   w_sum [NUM_CHAN];
    logic [COUNT_WIDTH-1:0] w_count;
    logic                   w_pending;
    t_dvs                   w_total;
    t_dvs                   w_divisor;
    t_dvd                   w_dividend [NUM_CHAN];
    logic [CHAN_W-1:0]      w_quot [NUM_CHAN];
    logic [CHAN_W-1:0]      w_fin [NUM_CHAN];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_ctrl.add  = w_in_acc && (i_func == FUNC_ADD);
    assign w_ctrl.clr  = w_in_acc && (i_func == FUNC_CLR);
    assign w_ctrl.upd  = w_in_acc && (i_func == FUNC_UPD);
    assign w_ctrl.mode = r_mix_mode;
    assign w_div_load  = w_ctrl.upd && w_pending;
    assign w_out_load  = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    rcm_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_red       (i_red_in),
        .i_green     (i_green_in),
        .i_blue      (i_blue_in),
        .o_red_sum   (w_sum[0]),
        .o_green_sum (w_sum[1]),
        .o_blue_sum  (w_sum[2]),
        .o_count     (w_count),
        .o_pending   (w_pending)
    );

    assign w_total   = t_dvs'(w_sum[0]) + t_dvs'(w_sum[1]) + t_dvs'(w_sum[2]);
    assign w_divisor = is_norm(r_mix_mode) ? w_total : t_dvs'(w_count);

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        assign w_dividend[g] = is_norm(r_mix_mode)
                             ? t_dvd'({w_sum[g], {CHAN_W{1'b0}}}) - t_dvd'(w_sum[g])
                             : t_dvd'(w_sum[g]);

        rcm_div u_div (
            .i_clk      (i_clk),
            .i_load     (w_div_load),
            .i_step     (r_state == ST_DIV),
            .i_dividend (w_dividend[g]),
            .i_divisor  (w_divisor),
            .o_quot     (w_quot[g])
        );

        always_comb begin
            if (is_norm(r_mix_mode)) begin
                w_fin[g] = r_div_zero ? '0 : w_quot[g];
            end else if (r_mix_mode == MODE_AVG) begin
                if (r_div_zero) begin
                    w_fin[g] = '0;
                end else if (t_cmp'(w_sum[g]) >= t_cmp'({w_count, {CHAN_W{1'b0}}})) begin
                    w_fin[g] = '1;
                end else begin
                    w_fin[g] = w_quot[g];
                end
            end else begin
                w_fin[g] = (w_sum[g][SUM_WIDTH-1:CHAN_W] != '0) ? '1 : w_sum[g][CHAN_W-1:0];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_ctrl.upd) begin
                    n_state = w_pending ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV: begin
                n_step_cnt = r_step_cnt + 1'b1;
                if (r_step_cnt == STEP_W'(CHAN_W - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step_cnt  <= '0;
            r_mix_mode  <= MODE_CAP;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
            if (i_cfg_valid) begin
                r_mix_mode <= i_cfg_mix_mode;
            end
            if (r_state == ST_FIN) begin
                for (int i = 0; i < NUM_CHAN; i++) begin
                    r_held[i] <= w_fin[i];
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_load) begin
            r_div_zero <= (w_divisor == '0);
        end
        if (w_out_load) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_out[i] <= r_held[i];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];

    `ASSERT_NEXT(a_upd_held_emit, i_clk, i_rst_n, w_ctrl.upd && !w_pending, r_state == ST_EMIT)
    `ASSERT_IMPL(a_cnt_in_div, i_clk, i_rst_n, r_step_cnt != '0, r_state == ST_DIV)
    `ASSERT_IMPL(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_EMIT)

endmodule

### sim/testbench.sv
// Self-checking bench for rgb_color_mix_accumulator: a directed table, random
// add/update/clear sequences and a long average run, scored by an in-bench color mixer.
// Depends on rcm_pkg and the block RTL only.
`timescale 1ns / 1ps

module testbench import rcm_pkg::*; ();

    localparam int          RAND_ITEMS  = 560;
    localparam int          BURST_ADDS  = 40;
    localparam int          LAT_WAIT    = 16;
    localparam int          HOLD_CYCLES = 400;
    localparam int          MAX_GAP     = 19;
    localparam longint      LIMIT       = 2_000_000;

    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FUNC_W-1:0] func;
        t_rgb              color;
        bit                typed;
        t_rgb              want;
    } t_dir_row;

    localparam t_rgb BLACK = '0;
    localparam t_rgb WHITE = '1;
    localparam int   DIR_ROWS = 30;

    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{MODE_CAP,    FUNC_UPD, BLACK,                    1'b1, BLACK},
        '{MODE_CAP,    FUNC_ADD, WHITE,                    1'b0, BLACK},
        '{MODE_CAP,    FUNC_ADD, BLACK,                    1'b0, BLACK},
        '{MODE_CAP,    FUNC_UPD, BLACK,                    1'b1, WHITE},
        '{MODE_CAP,    FUNC_UPD, BLACK,                    1'b1, WHITE},
        '{MODE_CAP,    FUNC_CLR, BLACK,                    1'b0, BLACK},
        '{MODE_CAP,    FUNC_UPD, BLACK,                    1'b1, WHITE},
        '{MODE_CAP,    FUNC_NOP, '{8'd1, 8'd2, 8'd3},      1'b0, BLACK},
        '{MODE_CAP,    FUNC_ADD, '{8'd200, 8'd17, 8'd3},   1'b0, BLACK},
        '{MODE_CAP,    FUNC_UPD, BLACK,                    1'b1, '{8'd200, 8'd17, 8'd3}},
        '{MODE_NORM,   FUNC_CLR, BLACK,                    1'b0, BLACK},
        '{MODE_NORM,   FUNC_ADD, BLACK,                    1'b0, BLACK},
        '{MODE_NORM,   FUNC_UPD, WHITE,                    1'b1, BLACK},
        '{MODE_NORM,   FUNC_ADD, '{8'd255, 8'd0, 8'd0},    1'b0, BLACK},
        '{MODE_NORM,   FUNC_UPD, BLACK,                    1'b1, '{8'd255, 8'd0, 8'd0}},
        '{MODE_MAX,    FUNC_ADD, '{8'd10, 8'd200, 8'd45},  1'b0, BLACK},
        '{MODE_MAX,    FUNC_ADD, '{8'd90, 8'd20, 8'd45},   1'b0, BLACK},
        '{MODE_MAX,    FUNC_UPD, BLACK,                    1'b0, BLACK},
        '{MODE_OVER,   FUNC_ADD, WHITE,                    1'b0, BLACK},
        '{MODE_OVER,   FUNC_ADD, '{8'd0, 8'd128, 8'd0},    1'b0, BLACK},
        '{MODE_OVER,   FUNC_UPD, BLACK,                    1'b1, '{8'd0, 8'd255, 8'd0}},
        '{MODE_CAP,    FUNC_CLR, BLACK,                    1'b0, BLACK},
        '{MODE_CAP,    FUNC_ADD, WHITE,                    1'b0, BLACK},
        '{MODE_CAP,    FUNC_ADD, WHITE,                    1'b0, BLACK},
        '{MODE_AVG,    FUNC_UPD, BLACK,                    1'b1, BLACK},
        '{MODE_AVG,    FUNC_ADD, '{8'd255, 8'd0, 8'd1},    1'b0, BLACK},
        '{MODE_AVG,    FUNC_UPD, BLACK,                    1'b1, WHITE},
        '{MODE_UNUSED, FUNC_CLR, BLACK,                    1'b0, BLACK},
        '{MODE_UNUSED, FUNC_ADD, '{8'd3, 8'd4, 8'd5},      1'b0, BLACK},
        '{MODE_UNUSED, FUNC_UPD, BLACK,                    1'b1, '{8'd3, 8'd4, 8'd5}}
    };

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] cfg_mode   = '0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [FUNC_W-1:0] func       = '0;
    logic [CHAN_W-1:0] red_in     = '0;
    logic [CHAN_W-1:0] green_in   = '0;
    logic [CHAN_W-1:0] blue_in    = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;

    // mixer state as the bench sees it
    logic [MODE_W-1:0]      mode_q = MODE_CAP;
    logic [SUM_WIDTH-1:0]   acc_r = '0, acc_g = '0, acc_b = '0;
    logic [COUNT_WIDTH-1:0] adds_n = '0;
    bit                     pend = 1'b0;
    t_rgb                   held = BLACK;

    t_rgb   mix_due [$];
    t_rgb   due_col;
    bit     brisk = 1'b0;
    bit     hold_req = 1'b0;
    int     mismatches = 0;
    int     beats_in = 0;
    int     results_seen = 0;
    int     mode_writes = 0;
    longint cycles = 0;

    rgb_color_mix_accumulator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_mix_mode (cfg_mode),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (func),
        .i_red_in       (red_in),
        .i_green_in     (green_in),
        .i_blue_in      (blue_in),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_red_out      (red_out),
        .o_green_out    (green_out),
        .o_blue_out     (blue_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, mix_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic flag(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [SUM_WIDTH-1:0] sum_sat(input logic [SUM_WIDTH-1:0] acc,
                                                     input logic [CHAN_W-1:0] c);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, acc} + c;
        return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] norm_chan(input longint unsigned c,
                                                    input longint unsigned tot);
        if (tot == 0) return '0;
        return CHAN_W'((c * 255) / tot);
    endfunction

    function automatic logic [CHAN_W-1:0] avg_chan(input longint unsigned c,
                                                   input longint unsigned n);
        if (n == 0) return '0;
        return (c / n > 255) ? 8'd255 : CHAN_W'(c / n);
    endfunction

    task automatic mix_predict(input logic [FUNC_W-1:0] f, input t_rgb c,
                               output bit emits, output t_rgb col);
        longint unsigned tot;
        emits = 1'b0;
        col   = held;
        case (f)
            FUNC_ADD: begin
                pend = 1'b1;
                if (mode_q == MODE_MAX) begin
                    if (c.red > acc_r)   acc_r = c.red;
                    if (c.green > acc_g) acc_g = c.green;
                    if (c.blue > acc_b)  acc_b = c.blue;
                end else if (mode_q == MODE_OVER) begin
                    acc_r = c.red;
                    acc_g = c.green;
                    acc_b = c.blue;
                end else begin
                    if (mode_q == MODE_AVG && adds_n != '1) adds_n = adds_n + 1'b1;
                    acc_r = sum_sat(acc_r, c.red);
                    acc_g = sum_sat(acc_g, c.green);
                    acc_b = sum_sat(acc_b, c.blue);
                end
            end
            FUNC_CLR: begin
                acc_r  = '0;
                acc_g  = '0;
                acc_b  = '0;
                adds_n = '0;
                pend   = 1'b0;
            end
            FUNC_UPD: begin
                if (pend) begin
                    if (mode_q == MODE_MAX || mode_q == MODE_NORM || mode_q == MODE_OVER) begin
                        tot = longint'(acc_r) + acc_g + acc_b;
                        held.red   = norm_chan(acc_r, tot);
                        held.green = norm_chan(acc_g, tot);
                        held.blue  = norm_chan(acc_b, tot);
                    end else if (mode_q == MODE_AVG) begin
                        held.red   = avg_chan(acc_r, adds_n);
                        held.green = avg_chan(acc_g, adds_n);
                        held.blue  = avg_chan(acc_b, adds_n);
                    end else begin
                        held.red   = (acc_r > 255) ? 8'd255 : acc_r[CHAN_W-1:0];
                        held.green = (acc_g > 255) ? 8'd255 : acc_g[CHAN_W-1:0];
                        held.blue  = (acc_b > 255) ? 8'd255 : acc_b[CHAN_W-1:0];
                    end
                    pend = 1'b0;
                end
                emits = 1'b1;
                col   = held;
            end
            default: ;
        endcase
    endtask

    // channel values lean on the extremes
    function automatic t_rgb rand_color();
        t_rgb c;
        logic [CHAN_W-1:0] v [3];
        for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 5))
                0:       v[j] = '0;
                1:       v[j] = '1;
                default: v[j] = CHAN_W'($urandom_range(0, 255));
            endcase
        end
        c.red   = v[0];
        c.green = v[1];
        c.blue  = v[2];
        return c;
    endfunction

    // entered and left at a rising edge
    task automatic drive_beat(input logic [FUNC_W-1:0] f, input t_rgb c,
                              input bit typed, input t_rgb want);
        int   gap;
        bit   em;
        t_rgb col;
        gap = brisk ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        red_in   <= c.red;
        green_in <= c.green;
        blue_in  <= c.blue;
        @(negedge i_clk);
        while (!in_ready) @(negedge i_clk);
        @(posedge i_clk);
        mix_predict(f, c, em, col);
        if (em) mix_due.push_back(typed ? want : col);
        if (f != FUNC_NOP) beats_in++;
    endtask

    // drains all results and lets trailing adds/clears retire before the write
    task automatic set_mix_mode(input logic [MODE_W-1:0] m);
        in_valid <= 1'b0;
        while (mix_due.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_mode  <= m;
        @(negedge i_clk);
        while (!cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        cfg_valid <= 1'b0;
        mode_q = m;
        mode_writes++;
    endtask

    initial begin
        int wait_n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            wait_n = brisk ? 0 : $urandom_range(0, MAX_GAP);
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(negedge i_clk);
            while (!out_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (mix_due.size() == 0) begin
                flag($sformatf("unexpected result %0d/%0d/%0d", red_out, green_out, blue_out));
            end else begin
                due_col = mix_due.pop_front();
                if (red_out !== due_col.red)
                    flag($sformatf("red got %0d want %0d", red_out, due_col.red));
                if (green_out !== due_col.green)
                    flag($sformatf("green got %0d want %0d", green_out, due_col.green));
                if (blue_out !== due_col.blue)
                    flag($sformatf("blue got %0d want %0d", blue_out, due_col.blue));
            end
        end
    end

    initial begin
        int i, k, n, done, r, phase, rand_items;
        logic [MODE_W-1:0] m;
        rand_items = 0;
        phase      = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].mode != mode_q) set_mix_mode(DIR_TAB[i].mode);
            drive_beat(DIR_TAB[i].func, DIR_TAB[i].color, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // each phase: drain, new mode, then add runs closed by an update, with noise
        while (rand_items < RAND_ITEMS) begin
            r = $urandom_range(0, 11);
            m = (r < 10) ? MODE_W'(r % 5) : MODE_W'($urandom_range(5, 7));
            set_mix_mode(m);
            brisk = (phase % 4 == 1);
            if (phase == 2) hold_req = 1'b1;
            n    = $urandom_range(40, 90);
            done = 0;
            while (done < n) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    k = $urandom_range(0, 3);
                    drive_beat(FUNC_W'(k), rand_color(), 1'b0, BLACK);
                    if (k != FUNC_NOP) done++;
                end else if (r == 1) begin
                    drive_beat(FUNC_UPD, rand_color(), 1'b0, BLACK);
                    done++;
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        drive_beat(FUNC_CLR, rand_color(), 1'b0, BLACK);
                        done++;
                    end
                    k = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                    repeat (k) drive_beat(FUNC_ADD, rand_color(), 1'b0, BLACK);
                    drive_beat(FUNC_UPD, rand_color(), 1'b0, BLACK);
                    done += k + 1;
                end
            end
            rand_items += done;
            phase++;
        end

        // back-to-back average run, then mode switches over the held sums
        brisk = 1'b1;
        set_mix_mode(MODE_AVG);
        drive_beat(FUNC_CLR, BLACK, 1'b0, BLACK);
        repeat (BURST_ADDS) drive_beat(FUNC_ADD, WHITE, 1'b0, BLACK);
        drive_beat(FUNC_UPD, BLACK, 1'b0, BLACK);
        set_mix_mode(MODE_NORM);
        drive_beat(FUNC_ADD, BLACK, 1'b0, BLACK);
        drive_beat(FUNC_UPD, BLACK, 1'b0, BLACK);
        set_mix_mode(MODE_CAP);
        drive_beat(FUNC_ADD, rand_color(), 1'b0, BLACK);
        drive_beat(FUNC_UPD, BLACK, 1'b0, BLACK);
        brisk = 1'b0;

        in_valid <= 1'b0;
        while (mix_due.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);

        $display("run: %0d beats in, %0d results out, %0d mode writes, %0d mismatches",
                 beats_in, results_seen, mode_writes, mismatches);
        $display("run: %0d directed rows, %0d random phases, %0d-add average run",
                 DIR_ROWS, phase, BURST_ADDS);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/rcm_pkg.sv
sv/rcm_div.sv
sv/rcm_acc.sv
sv/rgb_color_mix_accumulator.sv
sim/testbench.sv
